@@ rtl/core/number_to_english_words_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the number-to-words core
// Concurrent checks clocked on clk, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_ENGLISH_WORDS_CORE_ASSERT_SVH
`define NUMBER_TO_ENGLISH_WORDS_CORE_ASSERT_SVH

// Check that is switched off while reset is asserted.
`define NTEW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds across reset, used for reset behaviour itself.
`define NTEW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ntew_pkg.sv @@
// ----------------------------------------------------------------------------
// ntew_pkg
// Widths, word codes and helper functions shared by the number-to-words core.
// ----------------------------------------------------------------------------
`default_nettype none

package ntew_pkg;

  localparam int VALUE_W             = 40;
  localparam int WORD_W              = 5;
  localparam int NUM_DIGITS          = 12;
  localparam int BCD_W               = 4 * NUM_DIGITS;
  localparam int GROUP_W             = 12;
  localparam int NUM_GROUPS          = 4;
  localparam int SLOTS_PER_GROUP     = 5;
  localparam int NUM_SLOTS           = NUM_GROUPS * SLOTS_PER_GROUP;
  localparam int STEPS_PER_STAGE_DEF = 8;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 40'd999999999999;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BCD_W-1:0]  bcd_t;

  localparam word_t W_ZERO      = 5'd0;
  localparam word_t W_TEEN_BASE = 5'd10;
  localparam word_t W_TENS_BASE = 5'd18;
  localparam word_t W_HUNDRED   = 5'd28;
  localparam word_t W_THOUSAND  = 5'd29;
  localparam word_t W_MILLION   = 5'd30;
  localparam word_t W_BILLION   = 5'd31;

  // Position of each word within a group's run of slots.
  localparam int SLOT_HDIGIT  = 0;
  localparam int SLOT_HUNDRED = 1;
  localparam int SLOT_TENS    = 2;
  localparam int SLOT_ONES    = 3;
  localparam int SLOT_SCALE   = 4;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]             mask;
    logic [NUM_SLOTS-1:0][WORD_W-1:0] words;
    logic                             err;
  } plan_t;

  // One shift-and-add-three step of the binary to BCD conversion.
  function automatic bcd_t dabble_step(bcd_t bcd, logic bit_in);
    bcd_t       adj;
    logic [3:0] d;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[4*i +: 4];
      adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  function automatic logic bcd_valid(bcd_t bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic word_t scale_word(int g);
    word_t w;
    case (g)
      0:       w = W_BILLION;
      1:       w = W_MILLION;
      default: w = W_THOUSAND;
    endcase
    return w;
  endfunction

  // Lays out every word the number can produce in fixed slots, most
  // significant group first; the mask marks the slots that are spoken.
  function automatic plan_t make_plan(bcd_t bcd, logic err);
    plan_t      p;
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] o;
    int         base;
    p.mask  = '0;
    p.words = '0;
    p.err   = err;
    if (err || bcd == '0) begin
      p.mask[0]  = 1'b1;
      p.words[0] = W_ZERO;
    end else begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        h    = bcd[BCD_W-1-GROUP_W*g -: 4];
        t    = bcd[BCD_W-5-GROUP_W*g -: 4];
        o    = bcd[BCD_W-9-GROUP_W*g -: 4];
        base = g * SLOTS_PER_GROUP;
        if (h != 4'd0) begin
          p.mask[base+SLOT_HDIGIT]   = 1'b1;
          p.words[base+SLOT_HDIGIT]  = {1'b0, h};
          p.mask[base+SLOT_HUNDRED]  = 1'b1;
          p.words[base+SLOT_HUNDRED] = W_HUNDRED;
        end
        if (t >= 4'd2) begin
          p.mask[base+SLOT_TENS]  = 1'b1;
          p.words[base+SLOT_TENS] = W_TENS_BASE + {1'b0, t};
        end else if (t == 4'd1) begin
          p.mask[base+SLOT_TENS]  = 1'b1;
          p.words[base+SLOT_TENS] = W_TEEN_BASE + {1'b0, o};
        end
        if (t != 4'd1 && o != 4'd0) begin
          p.mask[base+SLOT_ONES]  = 1'b1;
          p.words[base+SLOT_ONES] = {1'b0, o};
        end
        if (g < NUM_GROUPS - 1 && (h | t | o) != 4'd0) begin
          p.mask[base+SLOT_SCALE]  = 1'b1;
          p.words[base+SLOT_SCALE] = scale_word(g);
        end
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ntew_if.sv @@
// ----------------------------------------------------------------------------
// ntew_if
// Valid/ready channel interfaces for the number input and the word output.
// ----------------------------------------------------------------------------
`default_nettype none

interface ntew_in_if;
  logic                         valid;
  logic                         ready;
  logic [ntew_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ntew_out_if;
  logic            valid;
  logic            ready;
  ntew_pkg::word_t word;
  logic            last;
  logic            error;

  modport source (output valid, output word, output last, output error, input ready);
  modport sink   (input valid, input word, input last, input error, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ntew_bcd_pipe.sv @@
// ----------------------------------------------------------------------------
// ntew_bcd_pipe
// Pipelined binary to BCD conversion with range check and stall handling.
// ----------------------------------------------------------------------------
`default_nettype none

module ntew_bcd_pipe #(
  parameter int STEPS_PER_STAGE = ntew_pkg::STEPS_PER_STAGE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ntew_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output ntew_pkg::bcd_t                    out_bcd,
  output logic                              out_err
);
  import ntew_pkg::*;

  localparam int NUM_STAGES = (VALUE_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int PAD_W      = NUM_STAGES * STEPS_PER_STAGE;

  logic [NUM_STAGES:0] vld_r;
  logic [NUM_STAGES:0] err_r;
  logic [NUM_STAGES:0] adv;
  bcd_t                bcd_r [0:NUM_STAGES];
  logic [PAD_W-1:0]    bin_r [0:NUM_STAGES];

  // The binary word is padded with leading zeros, which leave the BCD result
  // unchanged, so that every stage runs the same number of steps.
  function automatic logic [BCD_W+PAD_W-1:0] run_steps(bcd_t b_in, logic [PAD_W-1:0] r_in);
    bcd_t             b;
    logic [PAD_W-1:0] r;
    b = b_in;
    r = r_in;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      b = dabble_step(b, r[PAD_W-1]);
      r = {r[PAD_W-2:0], 1'b0};
    end
    return {b, r};
  endfunction

  // A stage may load when it is empty or its item moves on in this cycle.
  always_comb begin
    adv[NUM_STAGES] = !vld_r[NUM_STAGES] || out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      bin_r[0] <= PAD_W'(in_value);
      bcd_r[0] <= '0;
      err_r[0] <= in_value > VALUE_MAX;
    end
    for (int k = 1; k <= NUM_STAGES; k++) begin
      if (adv[k] && vld_r[k-1]) begin
        {bcd_r[k], bin_r[k]} <= run_steps(bcd_r[k-1], bin_r[k-1]);
        err_r[k] <= err_r[k-1];
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NUM_STAGES];
  assign out_bcd   = bcd_r[NUM_STAGES];
  assign out_err   = err_r[NUM_STAGES];

`include "number_to_english_words_core_assert.svh"

  `NTEW_ASSERT_RST(a_pipe_reset_empty, !rst_n |=> vld_r == '0, "pipeline not empty after reset")
  `NTEW_ASSERT(a_pipe_digits_ok, out_valid && !out_err |-> bcd_valid(out_bcd), "BCD digit out of range")
  `NTEW_ASSERT(a_pipe_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_bcd), "stalled conversion lost")

endmodule

`default_nettype wire

@@ rtl/core/number_to_english_words_core.sv @@
// ----------------------------------------------------------------------------
// number_to_english_words_core
// Spells an unsigned 40-bit number as a run of English word codes.
// ----------------------------------------------------------------------------
// Usage: numbers arrive on in_ch (valid/ready, one number per transaction).
// Each number produces a run of 1 to 19 word transactions on out_ch, most
// significant group first, with last set on the final word of the run. A
// value above 999999999999 gives a single word 0 with error and last set;
// zero gives the single word 0.
// Structure: with the default of 8 conversion steps per stage, the binary to
// BCD converter has ceil(40 / steps) stages plus an input register; a
// word-plan register and the output register follow it.
// Throughput: one word per cycle on out_ch while out_ch.ready is high; the
// word sequencer takes the next number as it issues the last word of the
// current one, so single-word numbers can be accepted every cycle.
// Reset clears every valid bit; the block then accepts a number at once.
// When out_ch stalls, the output register, word plan and converter stages
// hold their contents and in_ch.ready falls once all of them are full.
// ----------------------------------------------------------------------------
`default_nettype none

module number_to_english_words_core #(
  parameter int STEPS_PER_STAGE = ntew_pkg::STEPS_PER_STAGE_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ntew_in_if.sink    in_ch,
  ntew_out_if.source out_ch
);
  import ntew_pkg::*;

  logic  pipe_valid;
  logic  pipe_ready;
  bcd_t  pipe_bcd;
  logic  pipe_err;
  logic  in_ready;
  plan_t new_plan;

  logic [NUM_SLOTS-1:0]             plan_mask_r;
  logic [NUM_SLOTS-1:0]             plan_mask_nxt;
  logic [NUM_SLOTS-1:0][WORD_W-1:0] plan_words_r;
  logic                             plan_err_r;
  logic [NUM_SLOTS-1:0]             pick_oh;
  word_t                            pick_word;
  logic                             pick_last;
  logic                             plan_busy;
  logic                             plan_load;
  logic                             out_load;
  logic                             emit;

  logic  out_valid_r;
  logic  out_valid_nxt;
  word_t out_word_r;
  logic  out_last_r;
  logic  out_error_r;

  ntew_bcd_pipe #(
    .STEPS_PER_STAGE (STEPS_PER_STAGE)
  ) u_bcd_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_value  (in_ch.value),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_bcd   (pipe_bcd),
    .out_err   (pipe_err)
  );

  assign in_ch.ready = in_ready;
  assign new_plan    = make_plan(pipe_bcd, pipe_err);

  // The lowest pending slot is the next word; it is the last one when no
  // other slot remains.
  always_comb begin
    pick_oh   = plan_mask_r & (~plan_mask_r + NUM_SLOTS'(1));
    pick_last = (plan_mask_r & ~pick_oh) == '0;
    pick_word = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pick_word = pick_word | (plan_words_r[i] & {WORD_W{pick_oh[i]}});
    end
  end

  assign plan_busy  = plan_mask_r != '0;
  assign out_load   = !out_valid_r || out_ch.ready;
  assign emit       = out_load && plan_busy;
  assign pipe_ready = !plan_busy || (emit && pick_last);
  assign plan_load  = pipe_ready && pipe_valid;

  always_comb begin
    plan_mask_nxt = plan_mask_r;
    if (plan_load) begin
      plan_mask_nxt = new_plan.mask;
    end else if (emit) begin
      plan_mask_nxt = plan_mask_r & ~pick_oh;
    end
    out_valid_nxt = out_load ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_mask_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      plan_mask_r <= plan_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (plan_load) begin
      plan_words_r <= new_plan.words;
      plan_err_r   <= new_plan.err;
    end
    if (emit) begin
      out_word_r  <= pick_word;
      out_last_r  <= pick_last;
      out_error_r <= plan_err_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.word  = out_word_r;
  assign out_ch.last  = out_last_r;
  assign out_ch.error = out_error_r;

`include "number_to_english_words_core_assert.svh"

  `NTEW_ASSERT_RST(a_out_reset_idle, !rst_n |=> !out_valid_r, "output valid after reset")
  `NTEW_ASSERT(a_error_single_zero,
    out_valid_r && out_error_r |-> out_word_r == W_ZERO && out_last_r,
    "error word malformed")
  `NTEW_ASSERT(a_plan_max_words, $countones(plan_mask_r) <= NUM_SLOTS - 1,
    "plan holds too many words")
  `NTEW_ASSERT(a_plan_holds_in_stall, plan_busy && !emit |=> $stable(plan_mask_r),
    "pending words changed while stalled")

endmodule

`default_nettype wire
